@@ rtl/ccfp_pkg.sv @@
// Shared types, constants and the CRC byte update for the frame parser.
`timescale 1ns / 1ps
`default_nettype none
package ccfp_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [7:0]  START_BYTE_RESET = 8'hAA;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'h1021;

	// register index taken from paddr[2]
	localparam logic REG_START_BYTE = 1'b0;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN_HI  = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC_HI  = 3'd4,
		PH_CRC_LO  = 3'd5
	} phase_t;

	// CRC-16-CCITT, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/crc_checked_frame_parser.sv @@
// Length-prefixed frame parser with CRC-16-CCITT check, top level.
//  channel   dir  handshake              payload
//  input     in   in_valid / in_stall    rx_byte
//  output    out  out_valid / out_stall  data_byte, end_of_frame, crc_good, frame_length
//  config    in   APB write/read         start_byte at byte address 0
// One byte per cycle unless the output stalls: a byte is held in the input register, then the
// phase logic and the byte-wide CRC update load the output register.
// A result is registered after its byte leaves the input register; the CRC update is the longest path.
// arst_n clears the phase, counters and valid flags; start_byte resets to 0xAA.
// An output stall holds the result; the input stalls only when a byte waits
// in the input register behind a full, stalled output register.
`timescale 1ns / 1ps
`default_nettype none
module crc_checked_frame_parser (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       rx_byte,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [7:0]                            data_byte,
	output logic                                  end_of_frame,
	output logic                                  crc_good,
	output logic [15:0]                           frame_length,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ccfp_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [ccfp_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [ccfp_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                  pready
);

	logic [7:0]        start_byte_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	ccfp_pkg::phase_t  phase_q, phase_d;
	logic [15:0]       len_q, len_d;
	logic [15:0]       left_q, left_d;
	logic [15:0]       crc_q, crc_d;
	logic [7:0]        crc_hi_q, crc_hi_d;
	logic              res_valid, res_eof, res_good;
	logic [7:0]        res_data;
	logic [15:0]       left_dec;
	logic              advance, fire, in_accept;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ccfp_pkg::REG_START_BYTE) ?
		{{(ccfp_pkg::CFG_DATA_W-8){1'b0}}, start_byte_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= ccfp_pkg::START_BYTE_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == ccfp_pkg::REG_START_BYTE) begin
			start_byte_q <= pwdata[7:0];
		end
	end

	// handshake
	assign advance   = !out_valid || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	assign left_dec = left_q - 16'd1;

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		left_d    = left_q;
		crc_d     = crc_q;
		crc_hi_d  = crc_hi_q;
		res_valid = 1'b0;
		res_data  = 8'h00;
		res_eof   = 1'b0;
		res_good  = 1'b0;
		case (phase_q)
			ccfp_pkg::PH_LEN_HI: begin
				len_d   = {byte_s1, 8'h00};
				phase_d = ccfp_pkg::PH_LEN_LO;
			end
			ccfp_pkg::PH_LEN_LO: begin
				len_d   = {len_q[15:8], byte_s1};
				left_d  = {len_q[15:8], byte_s1};
				crc_d   = ccfp_pkg::CRC_INIT;
				phase_d = ({len_q[15:8], byte_s1} == 16'd0) ?
					ccfp_pkg::PH_CRC_HI : ccfp_pkg::PH_PAYLOAD;
			end
			ccfp_pkg::PH_PAYLOAD: begin
				crc_d     = ccfp_pkg::crc16_byte(crc_q, byte_s1);
				left_d    = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = ccfp_pkg::PH_CRC_HI;
				end
				res_valid = 1'b1;
				res_data  = byte_s1;
			end
			ccfp_pkg::PH_CRC_HI: begin
				crc_hi_d = byte_s1;
				phase_d  = ccfp_pkg::PH_CRC_LO;
			end
			ccfp_pkg::PH_CRC_LO: begin
				res_valid = 1'b1;
				res_eof   = 1'b1;
				res_good  = ({crc_hi_q, byte_s1} == crc_q);
				phase_d   = ccfp_pkg::PH_HUNT;
			end
			default: begin
				// hunting; unused codes fall back here
				phase_d = (byte_s1 == start_byte_q) ?
					ccfp_pkg::PH_LEN_HI : ccfp_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ccfp_pkg::PH_HUNT;
			len_q    <= '0;
			left_q   <= '0;
			crc_q    <= ccfp_pkg::CRC_INIT;
			crc_hi_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			left_q   <= left_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			data_byte    <= res_data;
			end_of_frame <= res_eof;
			crc_good     <= res_good;
			frame_length <= len_d;
		end
	end

	a_payload_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ccfp_pkg::PH_PAYLOAD |-> left_q != 16'd0)
		else $error("payload phase with no bytes left");

	a_eof_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_eof |=> phase_q == ccfp_pkg::PH_HUNT && out_valid && end_of_frame)
		else $error("end of frame did not return to hunting");

	a_eof_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> data_byte == 8'h00)
		else $error("end-of-frame item carries data");

	a_good_only_on_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_frame |-> !crc_good)
		else $error("crc_good set on a payload item");

	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with nothing waiting");

endmodule
`default_nettype wire
